@@ src/fbmp_pkg.sv @@
// ----------------------------------------------------------------------------
// fbmp_pkg
// Shared types, constants and tables for the fBm gradient noise pixel block.
// ----------------------------------------------------------------------------
package fbmp_pkg;

  localparam int MAX_OCTAVES = 8;
  localparam int ANGLE_BITS  = 10;
  localparam int PIXEL_BITS  = 12;

  localparam int ANG_N   = 1 << ANGLE_BITS;
  localparam int ANG_Q   = 1 << (ANGLE_BITS - 2);
  localparam int OCT_W   = $clog2(MAX_OCTAVES + 1);
  localparam int VAL_W   = 20;                      // octave value, Q16 signed
  localparam int ACC_W   = VAL_W + MAX_OCTAVES;     // weighted sum
  localparam int RCP_W   = 29;                      // reciprocal, Q28
  localparam int BX_W    = PIXEL_BITS + 32;         // pixel * step
  localparam int OCT_LAT = 9;                       // octave unit depth
  localparam int PIPE_LAT = OCT_LAT + 5;            // accept to result strobe

  // Hash multipliers
  localparam logic [31:0] HASH_C1 = 32'd3284157443;
  localparam logic [31:0] HASH_C2 = 32'd1911520717;
  localparam logic [31:0] HASH_C3 = 32'd2048419325;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_OCTAVE_COUNT = 2'd0;
  localparam logic [1:0] REG_STEP_X       = 2'd1;
  localparam logic [1:0] REG_STEP_Y       = 2'd2;

  localparam logic [31:0] OCTAVE_RST = 32'd1;
  localparam logic [31:0] STEP_RST   = 32'd65536;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_x;
    logic [PIXEL_BITS-1:0] pixel_y;
  } fbmp_in_t;

  typedef struct packed {
    logic [15:0]        noise_level;
    logic signed [15:0] noise_signed;
  } fbmp_out_t;

  typedef logic [15:0]      qsin_tab_t  [0:ANG_Q];
  typedef logic [RCP_W-1:0] recip_tab_t [0:MAX_OCTAVES];

  // Unsigned quotient by restoring shift and subtract, for table building
  function automatic longint unsigned udiv(input longint unsigned a,
                                           input longint unsigned d);
    longint unsigned q, rem;
    q = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], a[i]};
      if (rem >= d) begin
        rem = rem - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave sine, Taylor series in Q30 rounded to Q1.15
  function automatic qsin_tab_t build_qsin();
    qsin_tab_t         tab;
    longint unsigned   x, x2, term, div;
    longint            sum, q;
    for (int r = 0; r <= ANG_Q; r++) begin
      x = ((longint'(r) * 64'd6746518852) + (ANG_N >> 1)) >> ANGLE_BITS;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        div = longint'((2 * n) * (2 * n + 1));
        term = udiv((term * x2) >> 30, div);
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      q = (sum + 16384) >>> 15;
      if (q > 32767) q = 32767;
      tab[r] = 16'(q);
    end
    return tab;
  endfunction

  // round(2^28 / (2^n - 1)) per octave count
  function automatic recip_tab_t build_recip();
    recip_tab_t      tab;
    longint unsigned d;
    tab[0] = '0;
    for (int n = 1; n <= MAX_OCTAVES; n++) begin
      d = (64'd1 << n) - 64'd1;
      tab[n] = RCP_W'(udiv((64'd1 << 28) + (d >> 1), d));
    end
    return tab;
  endfunction

  localparam qsin_tab_t  QSIN  = build_qsin();
  localparam recip_tab_t RECIP = build_recip();

  // Full-wave sine from the quarter table
  function automatic logic signed [15:0] sin_lookup(input logic [ANGLE_BITS-1:0] k);
    logic [1:0]            q;
    logic [ANGLE_BITS-3:0] r;
    logic [15:0]           v;
    q = k[ANGLE_BITS-1 -: 2];
    r = k[ANGLE_BITS-3:0];
    v = q[0] ? QSIN[(ANGLE_BITS-1)'(ANG_Q) - {1'b0, r}] : QSIN[{1'b0, r}];
    return q[1] ? -$signed(v) : $signed(v);
  endfunction

  function automatic logic [31:0] rotl16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

endpackage

@@ src/fbmp_octave.sv @@
// ----------------------------------------------------------------------------
// fbmp_octave
// One octave of 2-D gradient noise, nine register stages, one sample a cycle.
// ----------------------------------------------------------------------------
module fbmp_octave import fbmp_pkg::*; (
  input  logic                    clk,
  input  logic [47:0]             cx,
  input  logic [47:0]             cy,
  output logic signed [VAL_W-1:0] value
);

  // Stage 1: first hash multiply, fade square
  logic [31:0] ax0_r, ax1_r, y0_r, y1_r, t2x_r, t2y_r;
  logic [15:0] fx1_r, fy1_r;
  logic [31:0] x0, y0;
  assign x0 = cx[47:16];
  assign y0 = cy[47:16];

  always_ff @(posedge clk) begin
    ax0_r <= x0 * HASH_C1;
    ax1_r <= (x0 + 32'd1) * HASH_C1;
    y0_r  <= y0;
    y1_r  <= y0 + 32'd1;
    fx1_r <= cx[15:0];
    fy1_r <= cy[15:0];
    t2x_r <= 32'(cx[15:0]) * 32'(cx[15:0]);
    t2y_r <= 32'(cy[15:0]) * 32'(cy[15:0]);
  end

  // Stage 2: second hash multiply, fade cube and polynomial
  logic [31:0] b_r [4];
  logic [31:0] ax0b_r, ax1b_r, t3x_r, t3y_r;
  logic [19:0] px_r, py_r;
  logic [15:0] fx2_r, fy2_r;
  logic [47:0] t3x_full, t3y_full;
  logic [36:0] px_full, py_full;

  always_comb begin
    t3x_full = 48'(t2x_r) * 48'(fx1_r);
    t3y_full = 48'(t2y_r) * 48'(fy1_r);
    px_full = ((37'd10 << 32) - 37'(fx1_r) * (37'd983040 - 37'd6 * 37'(fx1_r))) >> 16;
    py_full = ((37'd10 << 32) - 37'(fy1_r) * (37'd983040 - 37'd6 * 37'(fy1_r))) >> 16;
  end

  always_ff @(posedge clk) begin
    b_r[0] <= (y0_r ^ rotl16(ax0_r)) * HASH_C2;
    b_r[1] <= (y0_r ^ rotl16(ax1_r)) * HASH_C2;
    b_r[2] <= (y1_r ^ rotl16(ax0_r)) * HASH_C2;
    b_r[3] <= (y1_r ^ rotl16(ax1_r)) * HASH_C2;
    ax0b_r <= ax0_r;
    ax1b_r <= ax1_r;
    t3x_r  <= t3x_full[47:16];
    t3y_r  <= t3y_full[47:16];
    px_r   <= px_full[19:0];
    py_r   <= py_full[19:0];
    fx2_r  <= fx1_r;
    fy2_r  <= fy1_r;
  end

  // Stage 3: final hash multiply to angle index, fade weights
  logic [ANGLE_BITS-1:0] k_r [4];
  logic [16:0] wx3_r, wy3_r;
  logic [15:0] fx3_r, fy3_r;
  logic [31:0] h [4];
  logic [52:0] wx_full, wy_full;

  always_comb begin
    h[0] = (ax0b_r ^ rotl16(b_r[0])) * HASH_C3;
    h[1] = (ax1b_r ^ rotl16(b_r[1])) * HASH_C3;
    h[2] = (ax0b_r ^ rotl16(b_r[2])) * HASH_C3;
    h[3] = (ax1b_r ^ rotl16(b_r[3])) * HASH_C3;
    wx_full = 53'(t3x_r) * 53'(px_r) + (53'd1 << 31);
    wy_full = 53'(t3y_r) * 53'(py_r) + (53'd1 << 31);
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) k_r[c] <= h[c][30 -: ANGLE_BITS];
    wx3_r <= wx_full[48:32];
    wy3_r <= wy_full[48:32];
    fx3_r <= fx2_r;
    fy3_r <= fy2_r;
  end

  // Stage 4: gradient table lookup
  logic signed [15:0] gc_r [4];
  logic signed [15:0] gs_r [4];
  logic [16:0] wx4_r, wy4_r;
  logic [15:0] fx4_r, fy4_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      gc_r[c] <= sin_lookup(k_r[c] + ANGLE_BITS'(ANG_Q));
      gs_r[c] <= sin_lookup(k_r[c]);
    end
    wx4_r <= wx3_r;
    wy4_r <= wy3_r;
    fx4_r <= fx3_r;
    fy4_r <= fy3_r;
  end

  // Stage 5: corner dot products (offset minus one is the fraction with a sign bit)
  logic signed [33:0] dot_r [4];
  logic [16:0] wx5_r, wy5_r;
  logic signed [16:0] dxa, dxb, dya, dyb;

  assign dxa = $signed({1'b0, fx4_r});
  assign dxb = $signed({1'b1, fx4_r});
  assign dya = $signed({1'b0, fy4_r});
  assign dyb = $signed({1'b1, fy4_r});

  always_ff @(posedge clk) begin
    dot_r[0] <= dxa * gc_r[0] + dya * gs_r[0];
    dot_r[1] <= dxb * gc_r[1] + dya * gs_r[1];
    dot_r[2] <= dxa * gc_r[2] + dyb * gs_r[2];
    dot_r[3] <= dxb * gc_r[3] + dyb * gs_r[3];
    wx5_r <= wx4_r;
    wy5_r <= wy4_r;
  end

  // Stage 6: x blend products
  logic signed [52:0] ptop_r, pbot_r;
  logic signed [33:0] a_top_r, a_bot_r;
  logic [16:0] wy6_r;
  logic signed [34:0] d_top, d_bot;

  assign d_top = dot_r[1] - dot_r[0];
  assign d_bot = dot_r[3] - dot_r[2];

  always_ff @(posedge clk) begin
    ptop_r  <= d_top * $signed({1'b0, wx5_r});
    pbot_r  <= d_bot * $signed({1'b0, wx5_r});
    a_top_r <= dot_r[0];
    a_bot_r <= dot_r[2];
    wy6_r   <= wy5_r;
  end

  // Stage 7: x blend round and add
  logic signed [35:0] top_r, bot_r;
  logic [16:0] wy7_r;
  logic signed [52:0] ptop_rnd, pbot_rnd;

  assign ptop_rnd = ptop_r + 53'sd32768;
  assign pbot_rnd = pbot_r + 53'sd32768;

  always_ff @(posedge clk) begin
    top_r <= a_top_r + 36'(ptop_rnd >>> 16);
    bot_r <= a_bot_r + 36'(pbot_rnd >>> 16);
    wy7_r <= wy6_r;
  end

  // Stage 8: y blend product
  logic signed [54:0] pv_r;
  logic signed [35:0] top8_r;
  logic signed [36:0] d_v;

  assign d_v = bot_r - top_r;

  always_ff @(posedge clk) begin
    pv_r   <= d_v * $signed({1'b0, wy7_r});
    top8_r <= top_r;
  end

  // Stage 9: y blend round, scale to Q16
  logic signed [VAL_W-1:0] val_r;
  logic signed [54:0] pv_rnd;
  logic signed [36:0] vb, vb_rnd;

  always_comb begin
    pv_rnd = pv_r + 55'sd32768;
    vb     = top8_r + 37'(pv_rnd >>> 16);
    vb_rnd = vb + 37'sd16384;
  end

  always_ff @(posedge clk) begin
    val_r <= VAL_W'(vb_rnd >>> 15);
  end

  assign value = val_r;

endmodule

@@ src/fbm_perlin_noise_pixel.sv @@
// ----------------------------------------------------------------------------
// fbm_perlin_noise_pixel
// Fractal sum of 2-D gradient noise for one pixel coordinate per cycle.
// ----------------------------------------------------------------------------
// Use:
//   Drive in_pixel and raise start; a request is taken at every clock edge
//   with start high and busy low. busy stays low: one request per cycle is
//   taken, with no gaps.
//   Each request yields one result on out_res, marked by out_valid for one
//   cycle; results come out in request order, through 14 register stages,
//   the first loaded by the accept.
//   Throughput is one pixel per cycle: a coordinate scaling stage feeds one
//   nine-stage noise unit per octave, followed by a two-stage weighted sum,
//   a reciprocal multiply and an output saturation stage.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0 octave
//   count, 1 step x, 2 step y); other indexes are ignored. Write only while
//   no request is in flight.
//   Reset (rst_n low, synchronous) clears the valid pipeline and restores
//   octave count 1 and both steps to 1.0.
//   The receiver cannot stall; results must be taken when out_valid is high.
// ----------------------------------------------------------------------------
module fbm_perlin_noise_pixel import fbmp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  fbmp_in_t    in_pixel,
  output logic        out_valid,
  output fbmp_out_t   out_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers
  logic [3:0]  oct_cnt_r;
  logic [31:0] step_x_r, step_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cnt_r <= OCTAVE_RST[3:0];
      step_x_r  <= STEP_RST;
      step_y_r  <= STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OCTAVE_COUNT: oct_cnt_r <= cfg_data[3:0];
        REG_STEP_X:       step_x_r  <= cfg_data;
        REG_STEP_Y:       step_y_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective octave count, clamped to 1..MAX_OCTAVES
  logic [OCT_W-1:0] n_eff;
  always_comb begin
    if (oct_cnt_r == 4'd0) n_eff = OCT_W'(1);
    else if (32'(oct_cnt_r) > MAX_OCTAVES) n_eff = OCT_W'(MAX_OCTAVES);
    else n_eff = OCT_W'(oct_cnt_r);
  end

  assign busy = 1'b0;

  // Valid pipeline
  logic [PIPE_LAT-1:0] valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else valid_r <= {valid_r[PIPE_LAT-2:0], start & ~busy};
  end

  // Stage 1: scale pixel to noise coordinates
  logic [BX_W-1:0] bx_r, by_r;
  always_ff @(posedge clk) begin
    bx_r <= BX_W'(in_pixel.pixel_x) * BX_W'(step_x_r);
    by_r <= BX_W'(in_pixel.pixel_y) * BX_W'(step_y_r);
  end

  // Octave units, octave i at twice the frequency of octave i-1
  logic signed [VAL_W-1:0] oval [MAX_OCTAVES];
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    logic [47:0] cx_i, cy_i;
    assign cx_i = 48'(bx_r) << i;
    assign cy_i = 48'(by_r) << i;
    fbmp_octave u_oct (
      .clk   (clk),
      .cx    (cx_i),
      .cy    (cy_i),
      .value (oval[i])
    );
  end

  // Weight by 2^(n-1-i), sum in pairs
  localparam int PAIRS = (MAX_OCTAVES + 1) / 2;
  logic signed [ACC_W-1:0] term [2*PAIRS];
  logic signed [ACC_W-1:0] pair_r [PAIRS];

  always_comb begin
    for (int i = 0; i < 2 * PAIRS; i++) begin
      term[i] = '0;
      if (i < MAX_OCTAVES && OCT_W'(i) < n_eff)
        term[i] = ACC_W'(oval[i]) <<< (n_eff - OCT_W'(1) - OCT_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < PAIRS; p++) pair_r[p] <= term[2*p] + term[2*p+1];
  end

  // Final sum
  logic signed [ACC_W-1:0] acc_r, acc_sum;
  always_comb begin
    acc_sum = '0;
    for (int p = 0; p < PAIRS; p++) acc_sum = acc_sum + pair_r[p];
  end
  always_ff @(posedge clk) acc_r <= acc_sum;

  // Normalize by reciprocal of the weight sum
  localparam int PRD_W = ACC_W + RCP_W + 1;
  logic signed [PRD_W-1:0] nprod_r;
  always_ff @(posedge clk) begin
    nprod_r <= acc_r * $signed({1'b0, RECIP[n_eff]});
  end

  // Output rounding and saturation
  logic signed [PRD_W-1:0] nrnd;
  logic signed [31:0] v, s_full, lvl;
  fbmp_out_t res_nxt, res_r;

  always_comb begin
    nrnd   = nprod_r + (PRD_W'(1) <<< 27);
    v      = 32'(nrnd >>> 28);
    s_full = (v + 32'sd1) >>> 1;
    if (s_full > 32'sd32767) res_nxt.noise_signed = 16'sd32767;
    else if (s_full < -32'sd32768) res_nxt.noise_signed = -16'sd32768;
    else res_nxt.noise_signed = 16'(s_full);
    lvl = v + 32'sd65536;
    if (lvl < 0) lvl = '0;
    lvl = (lvl + 32'sd1) >>> 1;
    if (lvl > 32'sd65535) res_nxt.noise_level = 16'hFFFF;
    else res_nxt.noise_level = 16'(lvl);
  end

  always_ff @(posedge clk) res_r <= res_nxt;

  assign out_valid = valid_r[PIPE_LAT-1];
  assign out_res   = res_r;

  // Checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[0] |-> ##(PIPE_LAT-1) out_valid)
    else $error("request lost in pipeline");

  a_level_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.noise_level ==
      {~out_res.noise_signed[15], out_res.noise_signed[14:0]})
    else $error("level and signed outputs disagree");

  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("strobe after reset");

endmodule
